// File: rtl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

  // List capacity and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int ST_W     = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_RAW_W  = REQ_W + VAL_W + POS_W;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = VAL_W + ST_W + CNT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_REM_FRONT = 3'd3,
    REQ_REM_BACK  = 3'd4,
    REQ_REM_POS   = 3'd5
  } req_e;

  // Status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming request beat
    logic exec;  // apply the request and load the result register
  } ple_cmd_t;

endpackage

// File: rtl/positional_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a row of shifting
// cells. Each request beat inserts at the front, back or a position, or removes
// from the front, back or a position, and yields one result beat carrying the
// removed value (0 unless a remove succeeded), a status (ok, empty, bad
// position, full) and the count afterwards; a failed request leaves the list
// unchanged. A request is handled in order: the beat is captured first, then
// the cell row shifts and the result register loads; a new beat is accepted
// only after the previous request has executed. The result register lets a new
// request be captured while the previous result still waits; execution waits
// only if that result is not yet taken.
module positional_list_engine import ple_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  // req_type[2:0], value[34:3], position[39:35]
  input  logic [IN_W-1:0]  s_tdata_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  // removed_value[31:0], status[33:32], count[38:34], zero[39]
  output logic [OUT_W-1:0] m_tdata_o
);

  ple_cmd_t cmd;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .cmd_o       (cmd)
  );

  ple_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_tdata_i),
    .out_data_o (m_tdata_o)
  );

`ifndef ASSERT_OFF
  // A captured request blocks the input for the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input accepted while a request is in flight");

  // Reported count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[VAL_W+ST_W +: CNT_W] <= CNT_W'(CAPACITY)))
    else $error("count beyond capacity");

  // Failed requests return a zero removed value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tdata_o[VAL_W +: ST_W] != ST_OK)) |-> (m_tdata_o[VAL_W-1:0] == '0))
    else $error("nonzero removed value on error");

  // A full status only comes with a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tdata_o[VAL_W +: ST_W] == ST_FULL))
      |-> (m_tdata_o[VAL_W+ST_W +: CNT_W] == CNT_W'(CAPACITY)))
    else $error("full status with spare room");
`endif

endmodule

// File: rtl/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ple_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   exec;

  // Execute once the result register is free or being drained
  assign exec = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_ready_o && in_valid_i;
  assign cmd_o.exec  = exec;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result beat valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/ple_datapath.sv
`timescale 1ns / 1ps

module ple_datapath import ple_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ple_cmd_t         cmd_i,
  input  logic [IN_W-1:0]  in_data_i,
  output logic [OUT_W-1:0] out_data_o
);

  // Captured request
  logic [REQ_W-1:0] req_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;

  // Cell row and occupancy
  logic [VAL_W-1:0] cell_q [CAPACITY];
  logic [VAL_W-1:0] cell_d [CAPACITY];
  logic [CNT_W-1:0] occ_q, occ_d;

  // Result register
  logic [VAL_W-1:0] res_val_q, res_val_d;
  status_e          res_st_q, res_st_d;

  logic [CNT_W-1:0] ep;
  logic [CNT_W-1:0] pos_ext;
  logic             do_ins, do_rem;
  logic             is_full, is_empty;

  assign pos_ext  = CNT_W'(pos_q);
  assign is_full  = (occ_q >= CNT_W'(CAPACITY));
  assign is_empty = (occ_q == '0);

  // Decode the request, pick the effective position and check bounds
  always_comb begin
    ep        = '0;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    res_st_d  = ST_OK;
    unique case (req_q) inside
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
        if (req_q == REQ_INS_BACK) ep = occ_q;
        else if (req_q == REQ_INS_POS) ep = pos_ext;
        if (is_full) res_st_d = ST_FULL;
        else if (ep > occ_q) res_st_d = ST_BADPOS;
        else do_ins = 1'b1;
      end
      REQ_REM_FRONT, REQ_REM_BACK, REQ_REM_POS: begin
        if (req_q == REQ_REM_BACK) ep = occ_q - CNT_W'(1);
        else if (req_q == REQ_REM_POS) ep = pos_ext;
        if (is_empty) res_st_d = ST_EMPTY;
        else if (ep >= occ_q) res_st_d = ST_BADPOS;
        else do_rem = 1'b1;
      end
      default: ;
    endcase
  end

  // Removed value comes from the cell at the effective position
  assign res_val_d = do_rem ? cell_q[ep[IDX_W-1:0]] : '0;

  // Occupancy update
  always_comb begin
    occ_d = occ_q;
    if (do_ins) occ_d = occ_q + CNT_W'(1);
    else if (do_rem) occ_d = occ_q - CNT_W'(1);
  end

  // Each cell takes its own value, its left neighbor, its right neighbor or the new value
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cell_d[k] = cell_q[k];
      if (do_ins) begin
        if (CNT_W'(k) == ep) cell_d[k] = val_q;
        else if (CNT_W'(k) > ep) cell_d[k] = cell_q[(k > 0) ? k - 1 : 0];
      end else if (do_rem) begin
        if ((CNT_W'(k) >= ep) && (k < CAPACITY - 1)) cell_d[k] = cell_q[k + 1];
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i[REQ_W-1:0];
      val_q <= in_data_i[REQ_W +: VAL_W];
      pos_q <= in_data_i[REQ_W+VAL_W +: POS_W];
    end
  end

  // Cell row and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int k = 0; k < CAPACITY; k++) cell_q[k] <= cell_d[k];
      res_val_q <= res_val_d;
      res_st_q  <= res_st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.exec) begin
      occ_q <= occ_d;
    end
  end

  // Result beat: removed_value, status, count, zero pad
  assign out_data_o = {{(OUT_W-OUT_RAW_W){1'b0}}, occ_q, res_st_q, res_val_q};

endmodule
